FILE: rtl/usbcd_pkg.sv
// Package for the configuration descriptor parser: descriptor type codes,
// default table sizes and the result word type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package usbcd_pkg;

  // Descriptor type codes and endpoint attribute mask
  localparam logic [7:0] DESC_TYPE_IFACE   = 8'd4;
  localparam logic [7:0] DESC_TYPE_EP      = 8'd5;
  localparam logic [1:0] EP_ATTR_TYPE_MASK = 2'b11;

  // Default table sizes
  localparam int DEF_MAX_IFACES = 8;
  localparam int DEF_MAX_EPS    = 16;

  // Result kind codes
  localparam logic KIND_IFACE = 1'b0;
  localparam logic KIND_EP    = 1'b1;

  // One result word
  typedef struct packed {
    logic        record_kind;
    logic [2:0]  iface_slot;
    logic [3:0]  ep_slot;
    logic [7:0]  iface_number;
    logic [7:0]  alt_num;
    logic [7:0]  iface_class;
    logic [7:0]  iface_subclass;
    logic [7:0]  protocol_code;
    logic [7:0]  ep_address;
    logic [1:0]  ep_type;
    logic [15:0] max_packet;
    logic [7:0]  poll_interval;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/usbcd_walker.sv
// Record walker: tracks position in the descriptor stream, captures body
// bytes and allocates interface/endpoint slots. Uses usbcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usbcd_walker #(
  parameter int MAX_IFACES = usbcd_pkg::DEF_MAX_IFACES,
  parameter int MAX_EPS    = usbcd_pkg::DEF_MAX_EPS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  output logic                   res_valid,
  output usbcd_pkg::result_t     res
);
  import usbcd_pkg::*;

  localparam int IC_W = $clog2(MAX_IFACES + 1);
  localparam int EC_W = $clog2(MAX_EPS + 1);

  logic [7:0]      byte_offset, byte_offset_next;
  logic [7:0]      record_length, record_length_next;
  logic [7:0]      record_type, record_type_next;
  logic [7:0]      captured [6];
  logic [7:0]      captured_next [6];
  logic            halted, halted_next;
  logic            have_interface, have_interface_next;
  logic [IC_W-1:0] iface_count, iface_count_next;
  logic [EC_W-1:0] ep_count, ep_count_next;
  logic            done;
  logic [IC_W-1:0] last_iface;

  assign last_iface = iface_count - IC_W'(1);

  // Per-word state update and result
  always_comb begin
    byte_offset_next    = byte_offset;
    record_length_next  = record_length;
    record_type_next    = record_type;
    captured_next       = captured;
    halted_next         = halted;
    have_interface_next = have_interface;
    iface_count_next    = iface_count;
    ep_count_next       = ep_count;
    done                = 1'b0;
    res_valid           = 1'b0;
    res                 = '0;

    if (!halted) begin
      if (byte_offset == 8'd0) begin
        record_length_next = data_byte;
        if (data_byte == 8'd0) begin
          halted_next = 1'b1;
        end else begin
          record_type_next = 8'd0;
          for (int i = 0; i < 6; i++) captured_next[i] = 8'd0;
          done = (data_byte == 8'd1);
        end
      end else begin
        if (byte_offset == 8'd1) begin
          record_type_next = data_byte;
        end else begin
          for (int i = 0; i < 6; i++) begin
            if (byte_offset == 8'(i + 2)) captured_next[i] = data_byte;
          end
        end
        done = ({1'b0, byte_offset} + 9'd1) == {1'b0, record_length};
      end

      if (!halted_next) begin
        if (done) begin
          byte_offset_next = 8'd0;
          // Completed record: allocate a slot if possible
          if (record_type_next == DESC_TYPE_IFACE) begin
            if (iface_count < IC_W'(MAX_IFACES)) begin
              res_valid           = 1'b1;
              res.record_kind     = KIND_IFACE;
              res.iface_slot      = 3'(iface_count);
              res.iface_number    = captured_next[0];
              res.alt_num         = captured_next[1];
              res.iface_class     = captured_next[3];
              res.iface_subclass  = captured_next[4];
              res.protocol_code   = captured_next[5];
              iface_count_next    = iface_count + IC_W'(1);
              have_interface_next = 1'b1;
              ep_count_next       = '0;
            end
          end else if (record_type_next == DESC_TYPE_EP) begin
            if (have_interface && (ep_count < EC_W'(MAX_EPS))) begin
              res_valid         = 1'b1;
              res.record_kind   = KIND_EP;
              res.iface_slot    = 3'(last_iface);
              res.ep_slot       = 4'(ep_count);
              res.ep_address    = captured_next[0];
              res.ep_type       = captured_next[1][1:0] & EP_ATTR_TYPE_MASK;
              res.max_packet    = {captured_next[3], captured_next[2]};
              res.poll_interval = captured_next[4];
              ep_count_next     = ep_count + EC_W'(1);
            end
          end
        end else begin
          byte_offset_next = byte_offset + 8'd1;
        end
      end
    end

    // End of stream: back to the reset state
    if (last_byte) begin
      byte_offset_next    = 8'd0;
      record_length_next  = 8'd0;
      record_type_next    = 8'd0;
      for (int i = 0; i < 6; i++) captured_next[i] = 8'd0;
      halted_next         = 1'b0;
      have_interface_next = 1'b0;
      iface_count_next    = '0;
      ep_count_next       = '0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset    <= 8'd0;
      record_length  <= 8'd0;
      record_type    <= 8'd0;
      for (int i = 0; i < 6; i++) captured[i] <= 8'd0;
      halted         <= 1'b0;
      have_interface <= 1'b0;
      iface_count    <= '0;
      ep_count       <= '0;
    end else if (take) begin
      byte_offset    <= byte_offset_next;
      record_length  <= record_length_next;
      record_type    <= record_type_next;
      captured       <= captured_next;
      halted         <= halted_next;
      have_interface <= have_interface_next;
      iface_count    <= iface_count_next;
      ep_count       <= ep_count_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/usb_config_descriptor_parser.sv
// Top level of the configuration descriptor parser: input handshake, the
// record walker and the output result register. Uses usbcd_pkg, usbcd_walker.
`timescale 1ns / 1ps
`default_nettype none

// Takes one descriptor byte per cycle on the input channel and gives at most
// one result word per byte, in the cycle after the byte is taken, from a single
// output register. A byte is taken whenever that register is empty or being
// drained in the same cycle, so with out_ready held high the parser sustains
// one byte per clock; the output register alone sets that figure. last_byte
// returns all parser state to reset after its own byte has been handled. No
// memories, so there is no clearing pass after reset.
module usb_config_descriptor_parser #(
  parameter int MAX_IFACES = usbcd_pkg::DEF_MAX_IFACES,
  parameter int MAX_EPS    = usbcd_pkg::DEF_MAX_EPS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             record_kind,
  output logic [2:0]       iface_slot,
  output logic [3:0]       ep_slot,
  output logic [7:0]       iface_number,
  output logic [7:0]       alt_num,
  output logic [7:0]       iface_class,
  output logic [7:0]       iface_subclass,
  output logic [7:0]       protocol_code,
  output logic [7:0]       ep_address,
  output logic [1:0]       ep_type,
  output logic [15:0]      max_packet,
  output logic [7:0]       poll_interval
);
  import usbcd_pkg::*;

  logic    take;
  logic    res_valid;
  result_t res;
  result_t out_word;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  usbcd_walker #(
    .MAX_IFACES(MAX_IFACES),
    .MAX_EPS   (MAX_EPS)
  ) u_walker (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  // Output result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_word <= res;
    end
  end

  assign record_kind    = out_word.record_kind;
  assign iface_slot     = out_word.iface_slot;
  assign ep_slot        = out_word.ep_slot;
  assign iface_number   = out_word.iface_number;
  assign alt_num        = out_word.alt_num;
  assign iface_class    = out_word.iface_class;
  assign iface_subclass = out_word.iface_subclass;
  assign protocol_code  = out_word.protocol_code;
  assign ep_address     = out_word.ep_address;
  assign ep_type        = out_word.ep_type;
  assign max_packet     = out_word.max_packet;
  assign poll_interval  = out_word.poll_interval;

endmodule

`default_nettype wire

FILE: test/usb_config_descriptor_parser_tb.sv
// Self-checking bench for usb_config_descriptor_parser: descriptor byte streams in, per-record
// results checked against a cycle-free model of the record walker.
// Depends on usbcd_pkg and the parser RTL.
`timescale 1ns / 1ps

module usb_config_descriptor_parser_tb;
  import usbcd_pkg::*;

  localparam logic [7:0] DESC_CONFIG       = 8'd2;
  localparam logic [7:0] DESC_CS_INTERFACE = 8'h24;
  localparam int STREAM_BYTES   = 820;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic [7:0] data;
    logic       is_last;
  } desc_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        record_kind;
  logic [2:0]  iface_slot;
  logic [3:0]  ep_slot;
  logic [7:0]  iface_number;
  logic [7:0]  alt_num;
  logic [7:0]  iface_class;
  logic [7:0]  iface_subclass;
  logic [7:0]  protocol_code;
  logic [7:0]  ep_address;
  logic [1:0]  ep_type;
  logic [15:0] max_packet;
  logic [7:0]  poll_interval;

  usb_config_descriptor_parser uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .record_kind    (record_kind),
    .iface_slot     (iface_slot),
    .ep_slot        (ep_slot),
    .iface_number   (iface_number),
    .alt_num        (alt_num),
    .iface_class    (iface_class),
    .iface_subclass (iface_subclass),
    .protocol_code  (protocol_code),
    .ep_address     (ep_address),
    .ep_type        (ep_type),
    .max_packet     (max_packet),
    .poll_interval  (poll_interval)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pending descriptor words, predicted records and bookkeeping
  desc_word_t desc_bytes[$];
  result_t    expected_records[$];
  desc_word_t next_word;
  result_t    predicted;
  result_t    want;
  result_t    got_word;
  int         stream_total = 1;
  int         bytes_taken  = 0;
  int         error_count  = 0;
  int         quiet_cycles = 0;

  assign got_word = {record_kind, iface_slot, ep_slot, iface_number, alt_num, iface_class,
                     iface_subclass, protocol_code, ep_address, ep_type, max_packet,
                     poll_interval};

  // Walker model state
  logic [7:0] walk_pos;
  logic [7:0] walk_len;
  logic [7:0] walk_type;
  logic [7:0] walk_body [6];
  logic       walk_halted;
  logic       iface_seen;
  int         ifaces_used;
  int         eps_used;

  function automatic void reset_walker();
    walk_pos    = 8'd0;
    walk_len    = 8'd0;
    walk_type   = 8'd0;
    for (int i = 0; i < 6; i++) walk_body[i] = 8'd0;
    walk_halted = 1'b0;
    iface_seen  = 1'b0;
    ifaces_used = 0;
    eps_used    = 0;
  endfunction

  // Advance the walker by one byte; returns 1 when a record is stored
  function automatic bit parse_byte(input logic [7:0] b, input logic is_last,
                                    output result_t r);
    bit done;
    bit hit;
    int last_slot;
    done = 1'b0;
    hit  = 1'b0;
    r    = '0;
    if (!walk_halted) begin
      if (walk_pos == 8'd0) begin
        walk_len = b;
        if (b == 8'd0) begin
          walk_halted = 1'b1;
        end else begin
          walk_type = 8'd0;
          for (int i = 0; i < 6; i++) walk_body[i] = 8'd0;
          done = (b == 8'd1);
        end
      end else begin
        if (walk_pos == 8'd1) walk_type = b;
        else if (walk_pos <= 8'd7) walk_body[3'(walk_pos - 8'd2)] = b;
        done = (({1'b0, walk_pos} + 9'd1) == {1'b0, walk_len});
      end
      if (!walk_halted) begin
        if (done) begin
          if (walk_type == DESC_TYPE_IFACE && ifaces_used < DEF_MAX_IFACES) begin
            hit              = 1'b1;
            r.record_kind    = KIND_IFACE;
            r.iface_slot     = ifaces_used[2:0];
            r.iface_number   = walk_body[0];
            r.alt_num        = walk_body[1];
            r.iface_class    = walk_body[3];
            r.iface_subclass = walk_body[4];
            r.protocol_code  = walk_body[5];
            ifaces_used++;
            iface_seen = 1'b1;
            eps_used   = 0;
          end else if (walk_type == DESC_TYPE_EP && iface_seen &&
                       eps_used < DEF_MAX_EPS) begin
            // endpoints always attach to the most recently stored interface
            last_slot       = ifaces_used - 1;
            hit             = 1'b1;
            r.record_kind   = KIND_EP;
            r.iface_slot    = last_slot[2:0];
            r.ep_slot       = eps_used[3:0];
            r.ep_address    = walk_body[0];
            r.ep_type       = walk_body[1][1:0] & EP_ATTR_TYPE_MASK;
            r.max_packet    = {walk_body[3], walk_body[2]};
            r.poll_interval = walk_body[4];
            eps_used++;
          end
          walk_pos = 8'd0;
        end else begin
          walk_pos = walk_pos + 8'd1;
        end
      end
    end
    if (is_last) reset_walker();
    return hit;
  endfunction

  function automatic string show_result(input result_t r);
    return $sformatf({"kind %0d if %0d ep %0d num %02h alt %02h cls %02h sub %02h ",
                      "pro %02h adr %02h typ %0d mps %04h ivl %02h"},
                     r.record_kind, r.iface_slot, r.ep_slot, r.iface_number, r.alt_num,
                     r.iface_class, r.iface_subclass, r.protocol_code, r.ep_address,
                     r.ep_type, r.max_packet, r.poll_interval);
  endfunction

  // Idle percentages per phase: sender light / receiver heavy, swapped, then none
  function automatic int idle_pct(input bit sender_side);
    int ph;
    ph = (bytes_taken * 3) / stream_total;
    if (ph == 0) return sender_side ? 13 : 88;
    if (ph == 1) return sender_side ? 88 : 13;
    return 0;
  endfunction

  // Stream building
  task automatic put_byte(input logic [7:0] b);
    desc_word_t w;
    w.data    = b;
    w.is_last = 1'b0;
    desc_bytes.push_back(w);
  endtask

  task automatic put_record(input logic [7:0] len, input logic [7:0] kind);
    put_byte(len);
    if (len >= 8'd2) put_byte(kind);
    for (int k = 2; k < len; k++) put_byte(8'($urandom_range(255)));
  endtask

  task automatic close_stream();
    desc_word_t w;
    w = desc_bytes.pop_back();
    w.is_last = 1'b1;
    desc_bytes.push_back(w);
  endtask

  // Mostly the nominal length, sometimes short or over-long
  function automatic logic [7:0] pick_len(input int nominal);
    int r;
    r = $urandom_range(9);
    if (r == 7) return 8'($urandom_range(2, nominal - 1));
    if (r == 8) return 8'($urandom_range(nominal + 1, nominal + 4));
    return 8'(nominal);
  endfunction

  task automatic gen_stream();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      // well-formed configuration with random content
      put_record(8'd9, DESC_CONFIG);
      repeat ($urandom_range(1, 4)) begin
        put_record(pick_len(9), DESC_TYPE_IFACE);
        if ($urandom_range(3) == 0) put_record(8'($urandom_range(3, 9)), DESC_CS_INTERFACE);
        repeat ($urandom_range(0, 4)) put_record(pick_len(7), DESC_TYPE_EP);
      end
      if ($urandom_range(9) == 0) begin
        // record cut off by the end of the stream
        put_byte(8'd9);
        put_byte($urandom_range(1) ? DESC_TYPE_IFACE : DESC_TYPE_EP);
        repeat ($urandom_range(0, 5)) put_byte(8'($urandom_range(255)));
      end
    end else if (pick < 75) begin
      // many short records, around and beyond both table sizes
      repeat ($urandom_range(6, 11)) put_record(8'($urandom_range(2, 4)), DESC_TYPE_IFACE);
      repeat ($urandom_range(12, 19)) put_record(8'($urandom_range(2, 7)), DESC_TYPE_EP);
    end else if (pick < 85) begin
      // zero length stops the walk until the end of the stream
      put_record(8'd9, DESC_CONFIG);
      if ($urandom_range(1)) put_record(8'd9, DESC_TYPE_IFACE);
      put_byte(8'd0);
      repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(255)));
    end else if (pick < 95) begin
      repeat ($urandom_range(1, 16)) put_byte(8'($urandom_range(255)));
    end else begin
      put_record(8'($urandom_range(255)), 8'($urandom_range(255)));
    end
    close_stream();
  endtask

  // Driver: presents pending words, runs the model on each accepted word
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (parse_byte(data_byte, last_byte, predicted)) expected_records.push_back(predicted);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (desc_bytes.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          next_word = desc_bytes.pop_front();
          in_valid  <= 1'b1;
          data_byte <= next_word.data;
          last_byte <= next_word.is_last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // Monitor: each accepted result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result at %0t: %s", $time, show_result(got_word));
      end else begin
        want = expected_records.pop_front();
        if (got_word !== want) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch at %0t: expected %s, got %s", $time, show_result(want),
                     show_result(got_word));
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired at %0t", $time);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    reset_walker();

    // Directed: extremes, short endpoint, one-byte record, halt with ignored bytes
    put_byte(8'd9); put_byte(DESC_TYPE_IFACE); put_byte(8'hFF); put_byte(8'h00);
    put_byte(8'hAA); put_byte(8'hFF); put_byte(8'h00); put_byte(8'hFF); put_byte(8'h55);
    put_byte(8'd7); put_byte(DESC_TYPE_EP); put_byte(8'h81); put_byte(8'hFF);
    put_byte(8'hFF); put_byte(8'hFF); put_byte(8'h00);
    put_byte(8'd3); put_byte(DESC_TYPE_EP); put_byte(8'h02);
    put_byte(8'd1);
    put_byte(8'd0); put_byte(8'hFF); put_byte(8'h05);
    close_stream();
    // Directed: endpoint with no interface, short interface, record cut off
    put_byte(8'd2); put_byte(DESC_TYPE_EP);
    put_byte(8'd4); put_byte(DESC_TYPE_IFACE); put_byte(8'h12); put_byte(8'h34);
    put_byte(8'd9); put_byte(DESC_TYPE_EP); put_byte(8'h01);
    close_stream();

    while (desc_bytes.size() < STREAM_BYTES) gen_stream();
    stream_total = desc_bytes.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken != stream_total || expected_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_records.size() != 0) begin
      error_count += expected_records.size();
      $display("%0d expected results never arrived", expected_records.size());
    end
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/usbcd_pkg.sv
rtl/usbcd_walker.sv
rtl/usb_config_descriptor_parser.sv
test/usb_config_descriptor_parser_tb.sv
